// File: rtl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation pipeline.
`default_nettype none
package ptc_pkg;

	typedef enum logic [2:0] {
		REG_CAL_T1    = 3'd0,
		REG_CAL_T2    = 3'd1,
		REG_CAL_T3    = 3'd2,
		REG_CAL_P1    = 3'd3,
		REG_CAL_P2_P3 = 3'd4,
		REG_CAL_P4_P5 = 3'd5,
		REG_CAL_P6_P7 = 3'd6,
		REG_CAL_P8_P9 = 3'd7
	} cfg_reg_t;

	localparam int DivStages = 64;

	localparam logic signed [22:0] FINE_OFFSET = 23'sd128000;
	localparam logic signed [24:0] TC_ROUND    = 25'sd128;
	localparam logic signed [24:0] TC_SCALE    = 25'sd5;
	localparam logic signed [56:0] BIAS_47     = 57'sd140737488355328;
	localparam logic [20:0]        ADC_FULL    = 21'd1048576;
	localparam logic [11:0]        DIV_SCALE   = 12'd3125;

endpackage
`default_nettype wire

// File: rtl/pressure_temperature_compensation.sv
// Pipelined integer compensation of raw temperature and pressure readings.
`default_nettype none
// One reading pair is taken on every cycle at which start is high; busy is
// always low. Each transfer gives one result, shown for one cycle with done
// high. The depth is set by the 64-bit signed division, one quotient bit per
// pipeline stage (64 stages), with 11 stages before it and 6 after.
// pressure_valid is low, and pressure 0, when the divisor is zero.
// Calibration registers may only be written while no transfer is in flight.
module pressure_temperature_compensation (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [19:0]            adc_temperature,
	input  wire logic [19:0]            adc_pressure,
	input  wire logic                   cfg_we,
	input  wire ptc_pkg::cfg_reg_t      cfg_index,
	input  wire logic [31:0]            cfg_wdata,
	output logic                        done,
	output logic signed [31:0]          temperature_centi,
	output logic [31:0]                 pressure_q24_8,
	output logic                        pressure_valid
);
	import ptc_pkg::*;

	localparam int DivBase = 11;
	localparam int LATENCY = DivBase + DivStages + 6;

	// calibration
	logic [15:0]        cal_t1_q;
	logic signed [15:0] cal_t2_q, cal_t3_q;
	logic [15:0]        cal_p1_q;
	logic [31:0]        cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q    <= '0;
			cal_t2_q    <= '0;
			cal_t3_q    <= '0;
			cal_p1_q    <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_T1:    cal_t1_q    <= cfg_wdata[15:0];
				REG_CAL_T2:    cal_t2_q    <= $signed(cfg_wdata[15:0]);
				REG_CAL_T3:    cal_t3_q    <= $signed(cfg_wdata[15:0]);
				REG_CAL_P1:    cal_p1_q    <= cfg_wdata[15:0];
				REG_CAL_P2_P3: cal_p2_p3_q <= cfg_wdata;
				REG_CAL_P4_P5: cal_p4_p5_q <= cfg_wdata;
				REG_CAL_P6_P7: cal_p6_p7_q <= cfg_wdata;
				REG_CAL_P8_P9: cal_p8_p9_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [15:0] p2_c, p3_c, p4_c, p5_c, p6_c, p7_c, p8_c, p9_c;
	assign p2_c = $signed(cal_p2_p3_q[15:0]);
	assign p3_c = $signed(cal_p2_p3_q[31:16]);
	assign p4_c = $signed(cal_p4_p5_q[15:0]);
	assign p5_c = $signed(cal_p4_p5_q[31:16]);
	assign p6_c = $signed(cal_p6_p7_q[15:0]);
	assign p7_c = $signed(cal_p6_p7_q[31:16]);
	assign p8_c = $signed(cal_p8_p9_q[15:0]);
	assign p9_c = $signed(cal_p8_p9_q[31:16]);

	assign busy = 1'b0;

	// valid bits
	logic [LATENCY:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LATENCY-1:1], start};
		end
	end

	// stage 1: offsets
	logic signed [17:0] d1_c, d1_s1;
	logic signed [16:0] d2_c, d2_s1;
	logic [19:0]        ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	assign d1_c = $signed({1'b0, adc_temperature[19:3]}) - $signed({1'b0, cal_t1_q, 1'b0});
	assign d2_c = $signed({1'b0, adc_temperature[19:4]}) - $signed({1'b0, cal_t1_q});

	// stage 2
	logic signed [33:0] m1_c, m2_c;
	logic signed [31:0] m1w_c;
	logic signed [20:0] v1_s2, v1_s3;
	logic signed [31:0] sqt_s2;
	assign m1_c  = 34'(d1_s1) * 34'(cal_t2_q);
	assign m2_c  = 34'(d2_s1) * 34'(d2_s1);
	assign m1w_c = $signed(m1_c[31:0]);

	// stage 3
	logic signed [19:0] a20_c;
	logic signed [35:0] m3_c;
	logic signed [31:0] m3w_c;
	logic signed [17:0] v2_s3;
	assign a20_c = 20'(sqt_s2 >>> 12);
	assign m3_c  = 36'(a20_c) * 36'(cal_t3_q);
	assign m3w_c = $signed(m3_c[31:0]);

	// stage 4 and 5
	logic signed [21:0] fine_s4;
	logic signed [24:0] t5_c;
	logic signed [16:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic signed [22:0] var1_s5;
	assign t5_c = 25'(fine_s4) * TC_SCALE + TC_ROUND;

	// stage 6 to 8
	logic signed [45:0] sq_s6;
	logic signed [38:0] vp5_s6, vp2_s6, vp5_s7, vp2_s7;
	logic signed [61:0] a_s7, b_s7;
	logic signed [63:0] var2_s8;
	logic signed [55:0] var1b_s8;

	// stage 9 and 10
	logic signed [56:0] base_c;
	logic signed [73:0] m9p_c;
	logic signed [30:0] d_s9, d_s10;
	logic [20:0]        pp_c;
	logic [63:0]        x_s9, n_s10;
	assign base_c = 57'(var1b_s8) + BIAS_47;
	assign m9p_c  = 74'(base_c) * 74'($signed({1'b0, cal_p1_q}));
	assign pp_c   = ADC_FULL - {1'b0, ap_s8};

	always_ff @(posedge clk) begin
		d1_s1    <= d1_c;
		d2_s1    <= d2_c;
		ap_s1    <= adc_pressure;
		v1_s2    <= 21'(m1w_c >>> 11);
		sqt_s2   <= $signed(m2_c[31:0]);
		ap_s2    <= ap_s1;
		v1_s3    <= v1_s2;
		v2_s3    <= 18'(m3w_c >>> 14);
		ap_s3    <= ap_s2;
		fine_s4  <= 22'(v1_s3) + 22'(v2_s3);
		ap_s4    <= ap_s3;
		tc_s5    <= 17'(t5_c >>> 8);
		var1_s5  <= 23'(fine_s4) - FINE_OFFSET;
		ap_s5    <= ap_s4;
		sq_s6    <= 46'(var1_s5) * 46'(var1_s5);
		vp5_s6   <= 39'(var1_s5) * 39'(p5_c);
		vp2_s6   <= 39'(var1_s5) * 39'(p2_c);
		tc_s6    <= tc_s5;
		ap_s6    <= ap_s5;
		a_s7     <= 62'(sq_s6) * 62'(p6_c);
		b_s7     <= 62'(sq_s6) * 62'(p3_c);
		vp5_s7   <= vp5_s6;
		vp2_s7   <= vp2_s6;
		tc_s7    <= tc_s6;
		ap_s7    <= ap_s6;
		var2_s8  <= 64'(a_s7) + (64'(vp5_s7) <<< 17) + (64'(p4_c) <<< 35);
		var1b_s8 <= 56'(b_s7 >>> 8) + (56'(vp2_s7) <<< 12);
		tc_s8    <= tc_s7;
		ap_s8    <= ap_s7;
		d_s9     <= $signed(m9p_c[63:33]);
		x_s9     <= {12'b0, pp_c, 31'b0} - $unsigned(var2_s8);
		tc_s9    <= tc_s8;
		n_s10    <= x_s9 * {52'b0, DIV_SCALE};
		d_s10    <= d_s9;
		tc_s10   <= tc_s9;
	end

	// divider: one restoring step per stage, magnitudes only
	logic [30:0]        div_rem_s [0:DivStages];
	logic [63:0]        div_nq_s  [0:DivStages];
	logic [30:0]        div_md_s  [0:DivStages];
	logic               div_neg_s [0:DivStages];
	logic               div_ok_s  [0:DivStages];
	logic signed [16:0] div_tc_s  [0:DivStages];

	always_ff @(posedge clk) begin
		div_rem_s[0] <= '0;
		div_nq_s[0]  <= n_s10[63] ? (64'd0 - n_s10) : n_s10;
		div_md_s[0]  <= d_s10[30] ? $unsigned(-d_s10) : $unsigned(d_s10);
		div_neg_s[0] <= n_s10[63] ^ d_s10[30];
		div_ok_s[0]  <= d_s10 != '0;
		div_tc_s[0]  <= tc_s10;
	end

	for (genvar k = 1; k <= DivStages; k++) begin : g_div
		logic [31:0] trial_c;
		logic        ge_c;
		assign trial_c = {div_rem_s[k-1], div_nq_s[k-1][63]};
		assign ge_c    = trial_c >= {1'b0, div_md_s[k-1]};
		always_ff @(posedge clk) begin
			div_rem_s[k] <= ge_c ? 31'(trial_c - {1'b0, div_md_s[k-1]}) : trial_c[30:0];
			div_nq_s[k]  <= {div_nq_s[k-1][62:0], ge_c};
			div_md_s[k]  <= div_md_s[k-1];
			div_neg_s[k] <= div_neg_s[k-1];
			div_ok_s[k]  <= div_ok_s[k-1];
			div_tc_s[k]  <= div_tc_s[k-1];
		end
	end

	// post-division stages
	logic signed [63:0] p_s76, p_s77, p_s78, p_s79;
	logic signed [63:0] ph_c, ph_s77, m9_s77, e2m_c, e2_s77, e2_s78, e2_s79;
	logic [63:0]        ll_s78, prod_s79;
	logic [31:0]        lh_s78, hl_s78;
	logic signed [63:0] sum_s80, r_c;
	logic               ok_s76, ok_s77, ok_s78, ok_s79, ok_s80;
	logic signed [16:0] tc_s76, tc_s77, tc_s78, tc_s79, tc_s80;
	logic [31:0]        pr_c;

	assign ph_c  = p_s76 >>> 13;
	assign e2m_c = 64'(p8_c) * p_s76;
	assign r_c   = (sum_s80 >>> 8) + (64'(p7_c) <<< 4);

	always_comb begin
		if (r_c[63]) begin
			pr_c = '0;
		end else if (|r_c[62:32]) begin
			pr_c = '1;
		end else begin
			pr_c = r_c[31:0];
		end
	end

	logic signed [31:0] tc_s81;
	logic [31:0]        pr_s81;
	logic               ok_s81;

	always_ff @(posedge clk) begin
		p_s76    <= div_neg_s[DivStages] ? $signed(64'd0 - div_nq_s[DivStages])
		                                 : $signed(div_nq_s[DivStages]);
		ok_s76   <= div_ok_s[DivStages];
		tc_s76   <= div_tc_s[DivStages];
		p_s77    <= p_s76;
		ph_s77   <= ph_c;
		m9_s77   <= 64'(p9_c) * ph_c;
		e2_s77   <= e2m_c >>> 19;
		ok_s77   <= ok_s76;
		tc_s77   <= tc_s76;
		p_s78    <= p_s77;
		e2_s78   <= e2_s77;
		ll_s78   <= {32'b0, m9_s77[31:0]} * {32'b0, ph_s77[31:0]};
		lh_s78   <= 32'(m9_s77[31:0] * ph_s77[63:32]);
		hl_s78   <= 32'(m9_s77[63:32] * ph_s77[31:0]);
		ok_s78   <= ok_s77;
		tc_s78   <= tc_s77;
		p_s79    <= p_s78;
		e2_s79   <= e2_s78;
		prod_s79 <= ll_s78 + {32'(lh_s78 + hl_s78), 32'b0};
		ok_s79   <= ok_s78;
		tc_s79   <= tc_s78;
		sum_s80  <= p_s79 + ($signed(prod_s79) >>> 25) + e2_s79;
		ok_s80   <= ok_s79;
		tc_s80   <= tc_s79;
		tc_s81   <= 32'(tc_s80);
		pr_s81   <= ok_s80 ? pr_c : '0;
		ok_s81   <= ok_s80;
	end

	assign done              = vld_s[LATENCY];
	assign temperature_centi = tc_s81;
	assign pressure_q24_8    = pr_s81;
	assign pressure_valid    = ok_s81;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("transfer did not give a result at the expected cycle");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pressure_valid |-> pressure_q24_8 == '0)
		else $error("pressure not forced to zero on zero divisor");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DivBase + DivStages] && div_ok_s[DivStages]
			|-> div_rem_s[DivStages] < div_md_s[DivStages])
		else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire
